// ===== rtl/core/oal_pkg.sv =====
// Shared types and constants for the ordered array list engine.
// Used by the modules under rtl/core except oal_ram; depends on nothing.
`default_nettype none

package oal_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_POS   = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]               func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value_in;
    } t_in_word;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value_out;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         length;
    } t_out_word;

endpackage

`default_nettype wire

// ===== rtl/core/ordered_array_list_engine_unit.sv =====
// Ordered array list engine: a packed list of up to DEPTH signed words.
// Depends on oal_pkg and oal_seq.
//
// Usage:
//   Input channel (i_in_valid, i_in_word, o_in_stall) carries one request
//   word: func, position, value_in. Output channel (o_out_valid,
//   o_out_word, i_out_stall) returns one result word per request: status,
//   value_out, found_position and the list length after the operation.
//   Refused insert/delete/read requests and a find on an empty list go
//   straight to the result register. A read fetches one entry; an insert
//   at position p shifts entries p..length up by one, then writes value_in;
//   a delete moves the entries after p down by one; a find scans from the
//   first entry up to the match or to the end of the list.
//   Each shift or scan step moves one entry through the list RAM.
//   o_in_stall is high from accept until the result has moved to the output
//   register; the next request is accepted in the following cycle at the earliest.
//   A held result in the output register does not block the next request.
//   Reset empties the list (length 0) and drops any pending result; RAM
//   contents are not cleared. A stalled valid result holds in o_out_word.
`default_nettype none

module ordered_array_list_engine_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire oal_pkg::t_in_word  i_in_word,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output oal_pkg::t_out_word      o_out_word,
    input  wire logic               i_out_stall
);
    import oal_pkg::*;

    logic      seq_idle;
    logic      res_valid;
    logic      res_take;
    t_out_word res_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    oal_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_in_valid),
        .i_req_word (i_in_word),
        .o_idle     (seq_idle),
        .o_res_valid(res_valid),
        .o_res_word (res_word),
        .i_res_take (res_take)
    );

    // move a result out when the output register is empty or draining
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_word <= res_word;
        end
    end

    assign o_in_stall  = !seq_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ===== rtl/core/oal_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.
`default_nettype none

module oal_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/oal_seq.sv =====
// Operation sequencer: checks each request, walks the list RAM one entry a
// cycle (shift, scan or single read) and holds the length count.
// Depends on oal_pkg and oal_ram.
`default_nettype none

module oal_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire oal_pkg::t_in_word i_req_word,
    output logic                   o_idle,
    output logic                   o_res_valid,
    output oal_pkg::t_out_word     o_res_word,
    input  wire logic              i_res_take
);
    import oal_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [DATA_W-1:0] r_word, n_word;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_j, n_j;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pa, n_pa;
    logic [1:0]        r_status, n_status;
    logic [DATA_W-1:0] r_vout, n_vout;
    logic [POS_W-1:0]  r_fpos, n_fpos;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    logic [CNT_W:0]    req_pos_x, cnt_plus1;
    logic              req_pos_zero;

    oal_ram #(
        .ADDR_W(ADDR_W),
        .DATA_W(DATA_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign req_pos_x    = (CNT_W + 1)'(i_req_word.position);
    assign cnt_plus1    = {1'b0, r_cnt} + (CNT_W + 1)'(1);
    assign req_pos_zero = (i_req_word.position == '0);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_pos    = r_pos;
        n_word   = r_word;
        n_cnt    = r_cnt;
        n_j      = r_j;
        n_pend   = 1'b0;
        n_pa     = r_pa;
        n_status = r_status;
        n_vout   = r_vout;
        n_fpos   = r_fpos;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_word;
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(r_j);

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op     = i_req_word.func;
                    n_pos    = i_req_word.position;
                    n_word   = i_req_word.value_in;
                    n_vout   = '0;
                    n_fpos   = '0;
                    n_status = STS_OK;
                    n_state  = S_SCAN;
                    n_j      = CNT_W'(i_req_word.position - POS_W'(1));
                    case (i_req_word.func)
                        OP_INSERT: begin
                            n_j = r_cnt;
                            if (req_pos_zero || req_pos_x > cnt_plus1) begin
                                n_status = STS_BAD_POS;
                                n_state  = S_DONE;
                            end else if (r_cnt == CNT_W'(DEPTH)) begin
                                n_status = STS_FULL;
                                n_state  = S_DONE;
                            end
                        end
                        OP_FIND: begin
                            n_j      = '0;
                            n_status = STS_NOT_FOUND;
                            if (r_cnt == '0) begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            if (req_pos_zero || req_pos_x > {1'b0, r_cnt}) begin
                                n_status = STS_BAD_POS;
                                n_state  = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                case (r_op)
                    OP_INSERT: begin
                        // shift down from the top: read k-1, write it at k next cycle
                        if (r_pend) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pa + ADDR_W'(1);
                            ram_wdata = ram_rdata;
                        end
                        if (r_j >= CNT_W'(r_pos)) begin
                            ram_re    = 1'b1;
                            ram_raddr = ADDR_W'(r_j - CNT_W'(1));
                            n_pa      = ADDR_W'(r_j - CNT_W'(1));
                            n_pend    = 1'b1;
                            n_j       = r_j - CNT_W'(1);
                        end else if (!r_pend) begin
                            ram_we    = 1'b1;
                            ram_waddr = ADDR_W'(r_pos - POS_W'(1));
                            ram_wdata = r_word;
                            n_cnt     = r_cnt + CNT_W'(1);
                            n_state   = S_DONE;
                        end
                    end
                    OP_FIND: begin
                        if (r_pend && ram_rdata == r_word) begin
                            n_status = STS_OK;
                            n_fpos   = POS_W'(r_pa) + POS_W'(1);
                            n_state  = S_DONE;
                        end else if (r_j < r_cnt) begin
                            ram_re = 1'b1;
                            n_pa   = ADDR_W'(r_j);
                            n_pend = 1'b1;
                            n_j    = r_j + CNT_W'(1);
                        end else if (!r_pend) begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        // delete and read: the first word read is the result,
                        // delete then moves each later word down by one
                        if (r_pend) begin
                            if (r_pa == ADDR_W'(r_pos - POS_W'(1))) begin
                                n_vout = ram_rdata;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_pa - ADDR_W'(1);
                                ram_wdata = ram_rdata;
                            end
                        end
                        if ((r_op == OP_DELETE && r_j < r_cnt)
                                || (r_op == OP_READ && r_j < CNT_W'(r_pos))) begin
                            ram_re = 1'b1;
                            n_pa   = ADDR_W'(r_j);
                            n_pend = 1'b1;
                            n_j    = r_j + CNT_W'(1);
                        end else if (!r_pend) begin
                            if (r_op == OP_DELETE) begin
                                n_cnt = r_cnt - CNT_W'(1);
                            end
                            n_state = S_DONE;
                        end
                    end
                endcase
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_word   <= n_word;
        r_j      <= n_j;
        r_pa     <= n_pa;
        r_status <= n_status;
        r_vout   <= n_vout;
        r_fpos   <= n_fpos;
    end

    assign o_idle                    = (r_state == S_IDLE);
    assign o_res_valid               = (r_state == S_DONE);
    assign o_res_word.status         = r_status;
    assign o_res_word.value_out      = r_vout;
    assign o_res_word.found_position = r_fpos;
    assign o_res_word.length         = POS_W'(r_cnt);

endmodule

`default_nettype wire

// ===== rtl/core/oal_chk.sv =====
// Port-level checker for the ordered array list engine, bound to the top.
// Depends on oal_pkg and ordered_array_list_engine_unit.
`default_nettype none

module oal_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire oal_pkg::t_out_word o_out_word,
    input wire logic               i_out_stall
);
    import oal_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.length <= POS_W'(DEPTH))
        else $error("length above list depth");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == STS_FULL
            |-> o_out_word.length == POS_W'(DEPTH))
        else $error("full status with list not full");

    a_fpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.found_position <= o_out_word.length)
        else $error("found position beyond list length");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == STS_NOT_FOUND
            |-> o_out_word.found_position == '0 && o_out_word.value_out == '0)
        else $error("not-found result carries data");

endmodule

bind ordered_array_list_engine_unit oal_chk u_oal_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .o_out_word (o_out_word),
    .i_out_stall(i_out_stall)
);

`default_nettype wire

// ===== test/tb_ordered_array_list_engine_unit.sv =====
`timescale 1ns / 100ps
// Testbench for ordered_array_list_engine_unit: directed and random list requests
// against a cycle-free list predictor. Depends on oal_pkg and the engine RTL.

module tb_ordered_array_list_engine_unit;
    import oal_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int END_WAIT     = 80;

    typedef struct {
        t_in_word word;
        bit       drain;
    } t_pending_req;

    typedef enum int {PACE_FREE, PACE_LIGHT, PACE_HEAVY, PACE_TOGGLE} t_pace;
    typedef enum int {MIX_GROW, MIX_BALANCED, MIX_SHRINK} t_mix;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    t_pending_req request_queue[$];
    t_out_word    expected_results[$];

    // predicted list contents, advanced at request accept
    logic signed [DATA_W-1:0] list_mem [DEPTH];
    int                       list_len = 0;

    // generator-side length, used only to aim positions
    int                gen_len = 0;
    logic [DATA_W-1:0] value_pool [6];

    int    cycle_cnt    = 0;
    int    mismatch_cnt = 0;
    int    burst_left   = 8;
    int    gap_left     = 0;
    int    rx_cycle     = 0;
    int    long_hold    = 0;
    int    pace_left    = 0;
    t_pace rx_pace      = PACE_FREE;

    ordered_array_list_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    function automatic t_out_word apply_list_request(input t_in_word req);
        t_out_word res;
        int        p;
        int        k;
        res = '0;
        res.status = STS_OK;
        p = int'(req.position);
        case (req.func)
            OP_INSERT: begin
                if (p < 1 || p > list_len + 1) begin
                    res.status = STS_BAD_POS;
                end else if (list_len >= DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    for (k = list_len; k >= p; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[p-1] = req.value_in;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (p < 1 || p > list_len) begin
                    res.status = STS_BAD_POS;
                end else begin
                    res.value_out = list_mem[p-1];
                    for (k = p - 1; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            end
            OP_FIND: begin
                res.status = STS_NOT_FOUND;
                for (k = 0; k < list_len; k++) begin
                    if (list_mem[k] == req.value_in) begin
                        res.status = STS_OK;
                        res.found_position = POS_W'(k + 1);
                        break;
                    end
                end
            end
            default: begin
                if (p < 1 || p > list_len)
                    res.status = STS_BAD_POS;
                else
                    res.value_out = list_mem[p-1];
            end
        endcase
        res.length = POS_W'(list_len);
        return res;
    endfunction

    task automatic add_req(input logic [1:0] f, input int p, input logic [DATA_W-1:0] v,
                           input bit d);
        t_pending_req item;
        item.word.func     = f;
        item.word.position = POS_W'(p);
        item.word.value_in = v;
        item.drain         = d;
        request_queue.push_back(item);
        if (f == OP_INSERT && p >= 1 && p <= gen_len + 1 && gen_len < DEPTH)
            gen_len++;
        else if (f == OP_DELETE && p >= 1 && p <= gen_len)
            gen_len--;
    endtask

    function automatic int pick_pos(input logic [1:0] f);
        int top;
        int r;
        top = (f == OP_INSERT) ? gen_len + 1 : gen_len;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        if (r < 14)
            return top + 1;
        if (r < 20)
            return $urandom_range(0, 127);
        if (top < 1)
            return 1;
        if (r < 30)
            return top;
        if (r < 38)
            return 1;
        return $urandom_range(1, top);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(input logic [1:0] f);
        int r;
        int pool_cut;
        r = $urandom_range(0, 99);
        pool_cut = (f == OP_FIND) ? 50 : (f == OP_INSERT) ? 40 : 0;
        if (r < pool_cut)
            return value_pool[$urandom_range(0, 5)];
        if (r < pool_cut + 10) begin
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'hFFFF_FFFF;
                2:       return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // driver: offer pending words in bursts, predict each word as it is taken
    always @(posedge i_clk) begin : req_drive
        t_pending_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_results.push_back(apply_list_request(i_in_word));
            // a stalled word holds as it is
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (request_queue.size() != 0 &&
                             !(request_queue[0].drain && expected_results.size() != 0)) begin
                    nxt = request_queue.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_word  <= nxt.word;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver pacing, with two long hold-offs to back the engine up
    always @(posedge i_clk) begin : rx_stall
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle == 4000 || rx_cycle == 30000)
                long_hold = 600;
            if (pace_left == 0) begin
                rx_pace   = t_pace'($urandom_range(0, 3));
                pace_left = $urandom_range(20, 200);
            end else begin
                pace_left--;
            end
            if (long_hold > 0) begin
                long_hold--;
                i_out_stall <= 1'b1;
            end else begin
                case (rx_pace)
                    PACE_FREE:   i_out_stall <= 1'b0;
                    PACE_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
                    PACE_HEAVY:  i_out_stall <= ($urandom_range(0, 9) < 7);
                    default:     i_out_stall <= rx_cycle[0];
                endcase
            end
        end
    end

    // monitor: match each taken result word against the oldest prediction
    always @(posedge i_clk) begin : rsp_check
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result word with no request pending: %p", o_out_word);
                mismatch_cnt++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_word.status);
                    mismatch_cnt++;
                end
                if (o_out_word.value_out !== want.value_out) begin
                    $error("value_out: expected %0d, got %0d",
                           want.value_out, o_out_word.value_out);
                    mismatch_cnt++;
                end
                if (o_out_word.found_position !== want.found_position) begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, o_out_word.found_position);
                    mismatch_cnt++;
                end
                if (o_out_word.length !== want.length) begin
                    $error("length: expected %0d, got %0d", want.length, o_out_word.length);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin : timeout
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int   n_random;
        int   seg;
        int   seg_len;
        int   i;
        int   r;
        t_mix mix;
        logic [1:0] f;

        // directed: empty list, bad positions, append, duplicates, ends of the list
        add_req(OP_READ,     1, 32'h0000_0001, 1'b0);
        add_req(OP_DELETE,   1, 32'h0000_0002, 1'b0);
        add_req(OP_FIND,     0, 32'h0000_0000, 1'b0);
        add_req(OP_INSERT,   0, 32'h1111_1111, 1'b0);
        add_req(OP_INSERT,   2, 32'h2222_2222, 1'b0);
        add_req(OP_INSERT,   1, 32'h7FFF_FFFF, 1'b0);
        add_req(OP_INSERT,   2, 32'h8000_0000, 1'b0);
        add_req(OP_INSERT,   1, 32'hFFFF_FFFF, 1'b0);
        add_req(OP_INSERT,   2, 32'h0000_0000, 1'b0);
        add_req(OP_INSERT,   3, 32'hFFFF_FFFF, 1'b0);
        add_req(OP_FIND,     0, 32'hFFFF_FFFF, 1'b0);
        add_req(OP_FIND,   127, 32'h8000_0000, 1'b0);
        add_req(OP_FIND,     5, 32'h0000_3039, 1'b0);
        add_req(OP_READ,     0, 32'h0000_0000, 1'b0);
        add_req(OP_READ,     5, 32'hFFFF_FFFF, 1'b0);
        add_req(OP_READ,     6, 32'h0000_0000, 1'b0);
        add_req(OP_READ,   127, 32'h0000_0000, 1'b0);
        add_req(OP_DELETE,   6, 32'h0000_0000, 1'b0);
        add_req(OP_DELETE,   3, 32'h0000_0000, 1'b0);
        add_req(OP_DELETE,   1, 32'h0000_0000, 1'b0);
        add_req(OP_DELETE,   3, 32'h0000_0000, 1'b0);
        add_req(OP_INSERT, 127, 32'h5A5A_5A5A, 1'b0);
        add_req(OP_FIND,     1, 32'h0000_0000, 1'b0);
        add_req(OP_READ,     2, 32'h0000_0000, 1'b0);

        // random: rotate grow / balanced / shrink so the list fills and empties
        n_random = 0;
        seg = 0;
        while (n_random < RANDOM_ITEMS) begin
            seg_len = $urandom_range(40, 120);
            mix = t_mix'(seg % 3);
            for (i = 0; i < 6; i++)
                value_pool[i] = $urandom;
            for (i = 0; i < seg_len; i++) begin
                r = $urandom_range(0, 99);
                case (mix)
                    MIX_GROW:
                        f = (r < 80) ? OP_INSERT : (r < 85) ? OP_DELETE :
                            (r < 93) ? OP_FIND : OP_READ;
                    MIX_SHRINK:
                        f = (r < 10) ? OP_INSERT : (r < 75) ? OP_DELETE :
                            (r < 87) ? OP_FIND : OP_READ;
                    default:
                        f = (r < 30) ? OP_INSERT : (r < 55) ? OP_DELETE :
                            (r < 80) ? OP_FIND : OP_READ;
                endcase
                add_req(f, pick_pos(f), pick_value(f), (i == 0) && (seg % 4 == 0));
            end
            n_random += seg_len;
            seg++;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample between edges so the driver's updates have settled
        while (request_queue.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
